FILE: sv/prsh_pkg.sv
// Shared constants and types for the polynomial rolling string hash core.
package prsh_pkg;

    localparam int MOD_W = 32;              // modulus, hash and power width
    localparam int DVD_W = 64;              // widest dividend for the remainder unit
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int CHR_W = 8;
    localparam int POW31_W = MOD_W + 5;     // power times 31 fits in 37 bits
    localparam int PROD_W = MOD_W + 10;     // signed 9-bit factor times unsigned power

    localparam logic [MOD_W-1:0] RESET_MODULUS = MOD_W'(1024);
    localparam logic [4:0]       HASH_BASE     = 5'd31;
    localparam logic signed [8:0] CHAR_OFFSET  = 9'sd96;

    // Request to the remainder unit: dividend is left aligned, nbits of it are consumed.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_rsp;

endpackage

FILE: sv/prsh_mod_unit.sv
// Bit-serial restoring remainder unit: dividend modulo a 32-bit divisor, one bit per cycle.
module prsh_mod_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prsh_pkg::t_div_req          i_req,
    input  logic [prsh_pkg::DVD_W-1:0]  i_dividend,
    input  logic [prsh_pkg::MOD_W-1:0]  i_divisor,
    output prsh_pkg::t_div_rsp          o_rsp,
    output logic [prsh_pkg::MOD_W-1:0]  o_rem
);
    import prsh_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [MOD_W-1:0] r_rem;
    logic [MOD_W-1:0] r_m;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [MOD_W:0]   w_trial;
    logic [MOD_W:0]   w_diff;
    logic [MOD_W-1:0] n_rem;

    // Shift in the next dividend bit, subtract the divisor if it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_m};
        if (w_trial >= {1'b0, r_m}) begin
            n_rem = w_diff[MOD_W-1:0];
        end else begin
            n_rem = w_trial[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= i_req.nbits;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_m   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rem      = r_rem;

endmodule

FILE: sv/polynomial_rolling_string_hash_core.sv
// Top level of the polynomial rolling string hash core (base 31, modulo a bucket count).
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_char_byte (8 bits)
//  output  | out       | o_out_valid / i_out_ready  | o_bucket_hash (32 bits)
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_table_modulus (32 bits)
//
// A nonzero byte is processed in order: the term is formed, the reduction is started, the
// 64-bit new hash is reduced, the 37-bit new power is reduced and the sequencer returns to
// idle. A terminating zero byte reduces the 32-bit hash and loads the output register as
// it returns to idle. The single shared remainder unit serves all these steps; the input
// is not ready meanwhile.
// Reset is synchronous and active low; it restores the modulus to 1024, the hash to 0
// and the power to 1. A stalled output transaction is held in the output register while
// the next input transaction is taken; only a second finished hash waits for it.
module polynomial_rolling_string_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_bucket_hash,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_table_modulus
);
    import prsh_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_HSTART = 6'b000100,
        S_HRED   = 6'b001000,
        S_PRED   = 6'b010000,
        S_FRED   = 6'b100000
    } t_state;

    // Waiting for room in the output register is folded into the final reduction state.

    t_state              r_state, n_state;
    logic [MOD_W-1:0]    r_modulus;
    logic [MOD_W-1:0]    r_hash;
    logic [MOD_W-1:0]    r_power;
    logic [CHR_W-1:0]    r_byte;
    logic [DVD_W-1:0]    r_term;
    logic [POW31_W-1:0]  r_pow31;
    logic                r_out_valid;
    logic [MOD_W-1:0]    r_out_hash;
    logic                r_fin_pending;

    logic                w_in_acc;
    logic                w_cfg_acc;
    logic                w_out_free;
    logic [MOD_W-1:0]    w_eff_mod;
    logic signed [8:0]   w_factor;
    logic signed [PROD_W-1:0] w_prod;
    logic [DVD_W-1:0]    w_sum;
    t_div_req            w_req;
    t_div_rsp            w_rsp;
    logic [DVD_W-1:0]    w_dividend;
    logic [MOD_W-1:0]    w_rem;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // A modulus of zero behaves as a modulus of one.
    assign w_eff_mod = (r_modulus == '0) ? MOD_W'(1) : r_modulus;

    // The byte is a signed character; the factor (c - 96) lies in -224 .. 31.
    assign w_factor = $signed({r_byte[CHR_W-1], r_byte}) - CHAR_OFFSET;
    assign w_prod   = w_factor * $signed({1'b0, r_power});
    assign w_sum    = {{MOD_W{1'b0}}, r_hash} + r_term;

    // Remainder unit requests: the new hash (64 bits), the new power (37 bits)
    // or the final hash (32 bits), each left aligned in the dividend.
    always_comb begin
        w_req.start = 1'b0;
        w_req.nbits = CNT_W'(DVD_W);
        w_dividend  = w_sum;
        if (r_state == S_IDLE && w_in_acc && i_char_byte == '0) begin
            w_req.start = 1'b1;
            w_req.nbits = CNT_W'(MOD_W);
            w_dividend  = {r_hash, {(DVD_W-MOD_W){1'b0}}};
        end else if (r_state == S_HSTART) begin
            w_req.start = 1'b1;
        end else if (r_state == S_HRED && w_rsp.done) begin
            w_req.start = 1'b1;
            w_req.nbits = CNT_W'(POW31_W);
            w_dividend  = {r_pow31, {(DVD_W-POW31_W){1'b0}}};
        end
    end

    prsh_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_eff_mod),
        .o_rsp      (w_rsp),
        .o_rem      (w_rem)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_char_byte == '0) ? S_FRED : S_MUL;
                end
            end
            S_MUL:    n_state = S_HSTART;
            S_HSTART: n_state = S_HRED;
            S_HRED: begin
                if (w_rsp.done) begin
                    n_state = S_PRED;
                end
            end
            S_PRED: begin
                if (w_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            S_FRED: begin
                if ((w_rsp.done || r_fin_pending) && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_modulus     <= RESET_MODULUS;
            r_hash        <= '0;
            r_power       <= MOD_W'(1);
            r_out_valid   <= 1'b0;
            r_fin_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                r_modulus <= i_cfg_table_modulus;
            end
            // The terminator returns the running state to its start values at once;
            // the old hash has already been handed to the remainder unit.
            if (r_state == S_IDLE && w_in_acc && i_char_byte == '0) begin
                r_hash  <= '0;
                r_power <= MOD_W'(1);
            end
            if (r_state == S_HRED && w_rsp.done) begin
                r_hash <= w_rem;
            end
            if (r_state == S_PRED && w_rsp.done) begin
                r_power <= w_rem;
            end
            // The final remainder stays in the unit until the output register has room.
            if (r_state == S_FRED) begin
                if ((w_rsp.done || r_fin_pending) && w_out_free) begin
                    r_fin_pending <= 1'b0;
                end else if (w_rsp.done) begin
                    r_fin_pending <= 1'b1;
                end
            end
            if (r_state == S_FRED && (w_rsp.done || r_fin_pending) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_byte <= i_char_byte;
        end
        if (r_state == S_MUL) begin
            r_term  <= {{(DVD_W-PROD_W){w_prod[PROD_W-1]}}, w_prod};
            r_pow31 <= {{(POW31_W-MOD_W){1'b0}}, r_power} * HASH_BASE;
        end
        if (r_state == S_FRED && (w_rsp.done || r_fin_pending) && w_out_free) begin
            r_out_hash <= w_rem;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_bucket_hash = r_out_hash;

endmodule
